/* src/sltab_pkg.sv */
// Shared types and constants for the sorted list table.
// Holds the beat structs, command and status codes, and the store sizes.
package sltab_pkg;
	localparam int CAP = 64;
	localparam int AW = $clog2(CAP);
	localparam int CW = $clog2(CAP + 1);

	localparam logic [2:0] CMD_INSERT = 3'd0;
	localparam logic [2:0] CMD_POP    = 3'd1;
	localparam logic [2:0] CMD_ERASE  = 3'd2;
	localparam logic [2:0] CMD_FIND   = 3'd3;
	localparam logic [2:0] CMD_REMOVE = 3'd4;
	localparam logic [2:0] CMD_READ   = 3'd5;
	localparam logic [2:0] CMD_UNIQUE = 3'd6;

	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_FULL     = 3'd1;
	localparam logic [2:0] ST_EMPTY    = 3'd2;
	localparam logic [2:0] ST_HIGH     = 3'd3;
	localparam logic [2:0] ST_NOTFOUND = 3'd4;

	localparam logic signed [31:0] INT_MAX = 32'sh7fff_ffff;

	typedef struct packed {
		logic [2:0]         cmd;
		logic signed [31:0] value;
		logic [5:0]         index;
	} in_t;

	typedef struct packed {
		logic signed [31:0] result_value;
		logic [5:0]         result_index;
		logic [6:0]         entry_count;
		logic [6:0]         removed;
		logic [2:0]         status;
	} out_t;

	typedef struct packed {
		logic load;
		logic step;
	} ctl_t;

	typedef struct packed {
		logic done;
	} sts_t;
endpackage

/* src/sltab_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module sltab_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;
endmodule

/* src/sltab_ctrl.sv */
// Controller for the sorted list table: sequences load, read and step cycles.
// Depends on sltab_pkg.
module sltab_ctrl import sltab_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	output logic out_valid,
	input  logic out_stall,
	input  sts_t sts,
	output ctl_t ctl
);
	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_RD   = 2'd1;
	localparam logic [1:0] S_CMP  = 2'd2;
	localparam logic [1:0] S_OUT  = 2'd3;

	logic [1:0] state_q;

	assign in_stall = (state_q != S_IDLE);
	assign out_valid = (state_q == S_OUT);
	assign ctl.load = in_valid && (state_q == S_IDLE);
	assign ctl.step = (state_q == S_CMP);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= sts.done ? S_OUT : S_RD;
					end
				end
				S_RD: state_q <= S_CMP;
				S_CMP: begin
					state_q <= sts.done ? S_OUT : S_RD;
				end
				S_OUT: begin
					if (!out_stall) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall) else $error("input taken while result pending");
endmodule

/* src/sltab_dp.sv */
// Datapath for the sorted list table: entry RAM, count, scan pointers, result.
// Depends on sltab_pkg and sltab_ram.
module sltab_dp import sltab_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  in_t  in_data,
	input  ctl_t ctl,
	output sts_t sts,
	output out_t out_data
);
	logic [CW-1:0] cnt_q, cnt_d;
	logic [2:0] cmd_q, cmd_d;
	logic signed [31:0] val_q, val_d, last_q, last_d;
	logic [CW-1:0] rd_q, rd_d, wr_q, wr_d, rd1, wn, ix;
	logic first_q, first_d, place_q, place_d, keep, done;
	out_t res_q, res_d;
	logic we;
	logic [AW-1:0] wa;
	logic [31:0] wd, rdata;
	logic signed [31:0] rs;

	sltab_ram #(.WIDTH(32), .DEPTH(CAP)) u_ram (
		.clk(clk), .we(we), .waddr(wa), .wdata(wd),
		.raddr(rd_q[AW-1:0]), .rdata(rdata)
	);

	assign rs = $signed(rdata);
	assign rd1 = rd_q + CW'(1);

	always_comb begin
		cnt_d = cnt_q; cmd_d = cmd_q; val_d = val_q; last_d = last_q;
		rd_d = rd_q; wr_d = wr_q; first_d = first_q; place_d = place_q;
		res_d = res_q; we = 1'b0; wa = wr_q[AW-1:0]; wd = rdata; done = 1'b0;
		ix = '0; wn = wr_q; keep = 1'b0;
		if (ctl.load) begin
			cmd_d = in_data.cmd; val_d = in_data.value;
			first_d = 1'b1; place_d = 1'b0;
			res_d = '0;
			case (in_data.cmd)
				CMD_INSERT: begin
					if (cnt_q == CW'(CAP)) begin
						res_d.status = ST_FULL; done = 1'b1;
					end else if (cnt_q == '0) begin
						we = 1'b1; wa = '0; wd = in_data.value;
						cnt_d = CW'(1); done = 1'b1;
					end else begin
						rd_d = cnt_q - CW'(1); wr_d = cnt_q;
					end
				end
				CMD_POP, CMD_ERASE, CMD_READ: begin
					ix = (in_data.cmd == CMD_POP) ? '0 : CW'(in_data.index);
					if (cnt_q == '0) begin
						res_d.status = ST_EMPTY; res_d.result_value = INT_MAX; done = 1'b1;
					end else if (ix >= cnt_q) begin
						res_d.status = ST_HIGH; res_d.result_value = INT_MAX; done = 1'b1;
					end else begin
						rd_d = ix; wr_d = ix;
					end
				end
				CMD_FIND: begin
					if (cnt_q == '0) begin
						res_d.status = ST_NOTFOUND; done = 1'b1;
					end else begin
						rd_d = '0;
					end
				end
				CMD_REMOVE, CMD_UNIQUE: begin
					if (cnt_q == '0) begin
						done = 1'b1;
					end else begin
						rd_d = '0; wr_d = '0;
					end
				end
				default: done = 1'b1;
			endcase
		end else if (ctl.step) begin
			case (cmd_q)
				CMD_INSERT: begin
					we = 1'b1;
					if (place_q || !(rs > val_q)) begin
						wd = val_q; res_d.result_index = 6'(wr_q);
						cnt_d = cnt_q + CW'(1); done = 1'b1;
					end else begin
						wr_d = wr_q - CW'(1);
						if (rd_q == '0) begin
							place_d = 1'b1;
						end else begin
							rd_d = rd_q - CW'(1);
						end
					end
				end
				CMD_POP, CMD_ERASE, CMD_READ: begin
					first_d = 1'b0;
					if (first_q) begin
						res_d.result_value = rs;
					end else begin
						we = 1'b1; wr_d = wr_q + CW'(1);
					end
					if (first_q && cmd_q == CMD_READ) begin
						done = 1'b1;
					end else if (rd1 >= cnt_q) begin
						cnt_d = cnt_q - CW'(1); done = 1'b1;
					end else begin
						rd_d = rd1;
					end
				end
				CMD_FIND: begin
					if (rs == val_q) begin
						res_d.result_index = 6'(rd_q); done = 1'b1;
					end else if (rd1 >= cnt_q) begin
						res_d.status = ST_NOTFOUND; done = 1'b1;
					end else begin
						rd_d = rd1;
					end
				end
				CMD_REMOVE, CMD_UNIQUE: begin
					keep = (cmd_q == CMD_REMOVE) ? (rs != val_q) : (first_q || rs != last_q);
					first_d = 1'b0; last_d = rs;
					if (keep) begin
						we = 1'b1; wn = wr_q + CW'(1);
					end
					wr_d = wn;
					if (rd1 >= cnt_q) begin
						res_d.removed = 7'(cnt_q - wn); cnt_d = wn; done = 1'b1;
					end else begin
						rd_d = rd1;
					end
				end
				default: done = 1'b1;
			endcase
		end
		if (done) begin
			res_d.entry_count = 7'(cnt_d);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else begin
			cnt_q <= cnt_d;
		end
	end

	always_ff @(posedge clk) begin
		cmd_q <= cmd_d; val_q <= val_d; last_q <= last_d;
		rd_q <= rd_d; wr_q <= wr_d; first_q <= first_d; place_q <= place_d;
		res_q <= res_d;
	end

	assign sts.done = done;
	assign out_data = res_q;

	a_cnt_cap: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(CAP)) else $error("count above capacity");
	a_cnt_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!ctl.load && !ctl.step |=> $stable(cnt_q)) else $error("count moved while idle");
endmodule

/* src/sorted_list_table.sv */
// Sorted list table top level: up to 64 signed values kept in ascending order.
// Commands settled at once go straight to the result beat; else each step is one RAM read
// then one compare/write, and an insert at the front takes the most steps.
// One command at a time: the next beat is taken the cycle after the result beat has left.
// Reset (arst_n low, asynchronous) empties the table; RAM contents are not cleared.
module sorted_list_table import sltab_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  in_t  in_data,
	output logic out_valid,
	input  logic out_stall,
	output out_t out_data
);
	ctl_t ctl;
	sts_t sts;

	sltab_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.out_valid(out_valid), .out_stall(out_stall), .sts(sts), .ctl(ctl)
	);

	sltab_dp u_dp (
		.clk(clk), .arst_n(arst_n), .in_data(in_data), .ctl(ctl),
		.sts(sts), .out_data(out_data)
	);
endmodule
